### design/bilinear_alpha_weighted_sampler_defines.svh
`ifndef BILINEAR_ALPHA_WEIGHTED_SAMPLER_DEFINES_SVH
`define BILINEAR_ALPHA_WEIGHTED_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BAVS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BAVS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bavs_pkg.sv
package bavs_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int WEIGHT_FRAC = 8;

  localparam int PIX_W   = 8;
  localparam int CH_W    = 8;
  localparam int WORD_W  = 4 * CH_W;
  localparam int SIZE_W  = 9;
  localparam int COORD_W = 17;
  localparam int FRAC_IN = 16;

  localparam int T_W  = COORD_W + SIZE_W;
  localparam int TQ_W = T_W - FRAC_IN;

  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int BANK_AW    = (ROW_W - 1) + (COL_W - 1);
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  localparam int WGT_W = WEIGHT_FRAC + 1;
  localparam int WW_W  = 2 * WEIGHT_FRAC + 1;
  localparam int AW_W  = CH_W + WW_W;
  localparam int NW_W  = CH_W + AW_W;
  localparam int Q_W   = CH_W;

  localparam logic [T_W-1:0] T_HALF = T_W'(1) << (FRAC_IN - 1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // Per-sample texel qualifiers and axis weights; bank k = {row parity, col parity}.
  typedef struct packed {
    logic [3:0]       tex_ok;
    logic [WGT_W-1:0] wr_even;
    logic [WGT_W-1:0] wr_odd;
    logic [WGT_W-1:0] wc_even;
    logic [WGT_W-1:0] wc_odd;
  } tap_t;

  typedef struct packed {
    logic [2:0][NW_W-1:0] num;
    logic [AW_W-1:0]      den;
  } sum_t;

endpackage

### design/bavs_if.sv
interface bavs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bavs_pkg::PIX_W-1:0]   pix_row;
  logic [bavs_pkg::PIX_W-1:0]   pix_col;
  logic [bavs_pkg::CH_W-1:0]    in_red;
  logic [bavs_pkg::CH_W-1:0]    in_green;
  logic [bavs_pkg::CH_W-1:0]    in_blue;
  logic [bavs_pkg::CH_W-1:0]    in_alpha;
  logic [bavs_pkg::COORD_W-1:0] coord_u;
  logic [bavs_pkg::COORD_W-1:0] coord_v;

  modport source (
    output valid, op, pix_row, pix_col, in_red, in_green, in_blue, in_alpha,
           coord_u, coord_v,
    input  ready
  );
  modport sink (
    input  valid, op, pix_row, pix_col, in_red, in_green, in_blue, in_alpha,
           coord_u, coord_v,
    output ready
  );
endinterface

interface bavs_out_if;
  logic                      valid;
  logic                      ready;
  logic [bavs_pkg::CH_W-1:0] out_red;
  logic [bavs_pkg::CH_W-1:0] out_green;
  logic [bavs_pkg::CH_W-1:0] out_blue;
  logic [bavs_pkg::CH_W-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

### design/bilinear_alpha_weighted_sampler.sv
// Bilinear alpha-weighted RGBA8 sampler. Write items (op = 0) store one pixel
// at pix_row/pix_col; writes outside image_height x image_width are dropped.
// Sample items (op = 1) return one result: the 2x2 texel footprint around
// (coord_u * height, coord_v * width) with centers at +0.5, colors weighted by
// alpha and 8-bit-fraction bilinear weights, then divided by the blended
// alpha (zero alpha gives zero color); out_alpha is the blended alpha. Texels
// outside the image count with zero alpha. Throughput is one item per cycle
// unless the output stalls or the clearing pass runs. It has 3 fetch stages
// including the registered bank read, 4 multiply/accumulate stages, 8 divider
// stages, one quotient bit each. The pixel store is four parity banks, so the
// footprint is read in a single access. After reset a clearing pass zeroes
// the store, during which no item is accepted (config writes still land).
// Config writes only while idle.
module bilinear_alpha_weighted_sampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bavs_in_if.sink                     in_i,
  bavs_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bavs_pkg::SIZE_W-1:0] cfg_data_i
);

  localparam int SIZE_W = bavs_pkg::SIZE_W;

  logic [SIZE_W-1:0] width_q, width_d;
  logic [SIZE_W-1:0] height_q, height_d;
  logic [SIZE_W-1:0] eff_w, eff_h;

  // Register writes: unknown indexes fall through untouched.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (bavs_pkg::cfg_idx_e'(cfg_idx_i))
        bavs_pkg::CFG_WIDTH:  width_d  = cfg_data_i;
        bavs_pkg::CFG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(256);
      height_q <= SIZE_W'(256);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Zero acts as one; anything past the store size acts as the store size.
  always_comb begin
    eff_w = width_q;
    if (width_q == '0) begin
      eff_w = SIZE_W'(1);
    end else if (int'(width_q) > bavs_pkg::MAX_WIDTH) begin
      eff_w = SIZE_W'(bavs_pkg::MAX_WIDTH);
    end
    eff_h = height_q;
    if (height_q == '0) begin
      eff_h = SIZE_W'(1);
    end else if (int'(height_q) > bavs_pkg::MAX_HEIGHT) begin
      eff_h = SIZE_W'(bavs_pkg::MAX_HEIGHT);
    end
  end

  logic                             fetch_valid, fetch_ready;
  bavs_pkg::tap_t                   fetch_tap;
  logic [3:0][bavs_pkg::WORD_W-1:0] fetch_word;
  logic                             blend_valid, blend_ready;
  bavs_pkg::sum_t                   blend_sum;

  // Address, split and bank read.
  bavs_fetch u_fetch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .width_i     (eff_w),
    .height_i    (eff_h),
    .out_valid_o (fetch_valid),
    .out_ready_i (fetch_ready),
    .tap_o       (fetch_tap),
    .word_o      (fetch_word)
  );

  // Weights, alpha premultiply and footprint sums.
  bavs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fetch_valid),
    .in_ready_o  (fetch_ready),
    .tap_i       (fetch_tap),
    .word_i      (fetch_word),
    .out_valid_o (blend_valid),
    .out_ready_i (blend_ready),
    .sum_o       (blend_sum)
  );

  // Alpha normalization; its last stage is the output register.
  bavs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (blend_valid),
    .in_ready_o (blend_ready),
    .sum_i      (blend_sum),
    .out_o      (out_o)
  );

endmodule

### design/bavs_ram.sv
module bavs_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/bavs_fetch.sv
`include "bilinear_alpha_weighted_sampler_defines.svh"

module bavs_fetch (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  bavs_in_if.sink                                    in_i,
  input  logic [bavs_pkg::SIZE_W-1:0]                width_i,
  input  logic [bavs_pkg::SIZE_W-1:0]                height_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output bavs_pkg::tap_t                             tap_o,
  output logic [3:0][bavs_pkg::WORD_W-1:0]           word_o
);

  localparam int T_W     = bavs_pkg::T_W;
  localparam int TQ_W    = bavs_pkg::TQ_W;
  localparam int FRAC_IN = bavs_pkg::FRAC_IN;
  localparam int WGT_W   = bavs_pkg::WGT_W;
  localparam int ROW_W   = bavs_pkg::ROW_W;
  localparam int COL_W   = bavs_pkg::COL_W;
  localparam int BANK_AW = bavs_pkg::BANK_AW;
  localparam int WORD_W  = bavs_pkg::WORD_W;
  localparam int SIZE_W  = bavs_pkg::SIZE_W;

  typedef struct packed {
    logic [TQ_W-1:0]  ev_idx;
    logic [TQ_W-1:0]  od_idx;
    logic             ev_ok;
    logic             od_ok;
    logic [WGT_W-1:0] w_ev;
    logic [WGT_W-1:0] w_od;
  } axis_t;

  // Two neighbor indices, one of each parity, with weights and in-image flags.
  function automatic axis_t split_axis(input logic [T_W-1:0] t, input logic [SIZE_W-1:0] size);
    logic [TQ_W-1:0]  hi;
    logic [TQ_W-1:0]  lo;
    logic [TQ_W-1:0]  sz;
    logic [WGT_W-1:0] f;
    logic [WGT_W-1:0] one;
    logic             hi_ok;
    logic             lo_ok;
    axis_t            r;
    hi    = t[T_W-1:FRAC_IN];
    lo    = hi - TQ_W'(1);
    sz    = TQ_W'(size);
    f     = WGT_W'(t[FRAC_IN-1 -: bavs_pkg::WEIGHT_FRAC]);
    one   = WGT_W'(1) << bavs_pkg::WEIGHT_FRAC;
    hi_ok = hi < sz;
    lo_ok = (hi != '0) && (lo < sz);
    if (hi[0] == 1'b0) begin
      r.ev_idx = hi; r.ev_ok = hi_ok; r.w_ev = f;
      r.od_idx = lo; r.od_ok = lo_ok; r.w_od = one - f;
    end else begin
      r.od_idx = hi; r.od_ok = hi_ok; r.w_od = f;
      r.ev_idx = lo; r.ev_ok = lo_ok; r.w_ev = one - f;
    end
    return r;
  endfunction

  // Clearing pass
  logic               clr_q;
  logic [BANK_AW-1:0] clr_cnt_q;

  // Stage A
  logic               va_q;
  bavs_pkg::op_e      opa_q;
  logic [TQ_W-1:0]    rowa_q;
  logic [TQ_W-1:0]    cola_q;
  logic [WORD_W-1:0]  pixa_q;
  logic [T_W-1:0]     tua_q;
  logic [T_W-1:0]     tva_q;

  // Stage B
  logic               vb_q;
  bavs_pkg::op_e      opb_q;
  logic               wr_okb_q;
  logic [1:0]         wbankb_q;
  logic [BANK_AW-1:0] waddrb_q;
  logic [WORD_W-1:0]  pixb_q;
  logic [3:0][BANK_AW-1:0] raddrb_q;
  bavs_pkg::tap_t     tapb_q;

  // Stage C
  logic               vc_q;
  bavs_pkg::tap_t     tapc_q;

  logic en_a, en_b, en_c, acc;
  axis_t ax_u, ax_v;
  logic [3:0][BANK_AW-1:0] raddr_d;
  logic [3:0] ok_d;
  bavs_pkg::tap_t tap_d;

  assign en_c = !vc_q || out_ready_i;
  assign en_b = !vb_q || en_c;
  assign en_a = !va_q || en_b;
  assign in_i.ready = en_a && !clr_q;
  assign acc = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + BANK_AW'(1);
      if (clr_cnt_q == '1) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= acc;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q && (opb_q == bavs_pkg::OP_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      opa_q  <= bavs_pkg::op_e'(in_i.op);
      rowa_q <= TQ_W'(in_i.pix_row);
      cola_q <= TQ_W'(in_i.pix_col);
      pixa_q <= {in_i.in_alpha, in_i.in_blue, in_i.in_green, in_i.in_red};
      tua_q  <= T_W'(in_i.coord_u) * T_W'(height_i) + bavs_pkg::T_HALF;
      tva_q  <= T_W'(in_i.coord_v) * T_W'(width_i) + bavs_pkg::T_HALF;
    end
  end

  always_comb begin
    ax_u = split_axis(tua_q, height_i);
    ax_v = split_axis(tva_q, width_i);
    for (int k = 0; k < 4; k++) begin
      raddr_d[k] = {(k[1] ? ax_u.od_idx[ROW_W-1:1] : ax_u.ev_idx[ROW_W-1:1]),
                    (k[0] ? ax_v.od_idx[COL_W-1:1] : ax_v.ev_idx[COL_W-1:1])};
      ok_d[k]    = (k[1] ? ax_u.od_ok : ax_u.ev_ok) && (k[0] ? ax_v.od_ok : ax_v.ev_ok);
    end
    tap_d.tex_ok  = ok_d;
    tap_d.wr_even = ax_u.w_ev;
    tap_d.wr_odd  = ax_u.w_od;
    tap_d.wc_even = ax_v.w_ev;
    tap_d.wc_odd  = ax_v.w_od;
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      opb_q    <= opa_q;
      wr_okb_q <= (rowa_q < TQ_W'(height_i)) && (cola_q < TQ_W'(width_i));
      wbankb_q <= {rowa_q[0], cola_q[0]};
      waddrb_q <= {rowa_q[ROW_W-1:1], cola_q[COL_W-1:1]};
      pixb_q   <= pixa_q;
      raddrb_q <= raddr_d;
      tapb_q   <= tap_d;
    end
    if (en_c) begin
      tapc_q <= tapb_q;
    end
  end

  // Four banks by row and column parity: the 2x2 footprint hits each once.
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic we;
    assign we = clr_q || (en_c && vb_q && (opb_q == bavs_pkg::OP_WRITE) && wr_okb_q
                          && (wbankb_q == 2'(k)));
    bavs_ram #(
      .DATA_W (WORD_W),
      .DEPTH  (bavs_pkg::BANK_DEPTH)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (clr_q ? clr_cnt_q : waddrb_q),
      .wdata_i (clr_q ? '0 : pixb_q),
      .re_i    (en_c),
      .raddr_i (raddrb_q[k]),
      .rdata_o (word_o[k])
    );
  end

  assign out_valid_o = vc_q;
  assign tap_o       = tapc_q;

  `BAVS_ASSERT_IMP(a_no_accept_in_clear, clr_q, !in_i.ready, "item accepted during clear")
  `BAVS_ASSERT_NXT(a_clear_ends, clr_q && (clr_cnt_q == '1), !clr_q, "clear pass overran")
  `BAVS_ASSERT_NXT(a_clear_once, !clr_q, !clr_q, "clear pass restarted")
  `BAVS_ASSERT_NXT(a_b_hold, vb_q && !en_c, vb_q && $stable(raddrb_q), "stage B lost item")

endmodule

### design/bavs_blend.sv
module bavs_blend (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bavs_pkg::tap_t                   tap_i,
  input  logic [3:0][bavs_pkg::WORD_W-1:0] word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bavs_pkg::sum_t                   sum_o
);

  localparam int CH_W  = bavs_pkg::CH_W;
  localparam int WW_W  = bavs_pkg::WW_W;
  localparam int AW_W  = bavs_pkg::AW_W;
  localparam int NW_W  = bavs_pkg::NW_W;
  localparam int WGT_W = bavs_pkg::WGT_W;

  logic vd_q, ve_q, vf_q, vg_q;
  logic en_d, en_e, en_f, en_g;

  logic [3:0][CH_W-1:0]       alphad_q;
  logic [3:0][2:0][CH_W-1:0]  cold_q;
  logic [3:0][WW_W-1:0]       wd_q;
  logic [3:0][2:0][CH_W-1:0]  cole_q;
  logic [3:0][AW_W-1:0]       awe_q;
  logic [3:0][2:0][NW_W-1:0]  pf_q;
  logic [AW_W-1:0]            af_q;
  bavs_pkg::sum_t             sumg_q;

  assign en_g = !vg_q || out_ready_i;
  assign en_f = !vf_q || en_g;
  assign en_e = !ve_q || en_f;
  assign en_d = !vd_q || en_e;
  assign in_ready_o = en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else begin
      if (en_d) vd_q <= in_valid_i;
      if (en_e) ve_q <= vd_q;
      if (en_f) vf_q <= ve_q;
      if (en_g) vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [WGT_W-1:0] wr;
    logic [WGT_W-1:0] wc;
    logic [NW_W-1:0]  nsum;
    logic [AW_W-1:0]  asum;
    if (en_d) begin
      for (int k = 0; k < 4; k++) begin
        wr = k[1] ? tap_i.wr_odd : tap_i.wr_even;
        wc = k[0] ? tap_i.wc_odd : tap_i.wc_even;
        // Texels outside the image carry zero alpha.
        alphad_q[k] <= tap_i.tex_ok[k] ? word_i[k][4*CH_W-1:3*CH_W] : '0;
        for (int c = 0; c < 3; c++) begin
          cold_q[k][c] <= word_i[k][c*CH_W +: CH_W];
        end
        wd_q[k] <= WW_W'(wr) * WW_W'(wc);
      end
    end
    if (en_e) begin
      for (int k = 0; k < 4; k++) begin
        awe_q[k] <= AW_W'(alphad_q[k]) * AW_W'(wd_q[k]);
      end
      cole_q <= cold_q;
    end
    if (en_f) begin
      asum = '0;
      for (int k = 0; k < 4; k++) begin
        asum = asum + awe_q[k];
        for (int c = 0; c < 3; c++) begin
          pf_q[k][c] <= NW_W'(cole_q[k][c]) * NW_W'(awe_q[k]);
        end
      end
      af_q <= asum;
    end
    if (en_g) begin
      for (int c = 0; c < 3; c++) begin
        nsum = '0;
        for (int k = 0; k < 4; k++) begin
          nsum = nsum + pf_q[k][c];
        end
        sumg_q.num[c] <= nsum;
      end
      sumg_q.den <= af_q;
    end
  end

  assign out_valid_o = vg_q;
  assign sum_o       = sumg_q;

endmodule

### design/bavs_div.sv
module bavs_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bavs_pkg::sum_t sum_i,
  bavs_out_if.source     out_o
);

  localparam int Q_W  = bavs_pkg::Q_W;
  localparam int NW_W = bavs_pkg::NW_W;
  localparam int AW_W = bavs_pkg::AW_W;
  localparam int CH_W = bavs_pkg::CH_W;
  localparam int A_SH = 2 * bavs_pkg::WEIGHT_FRAC;

  logic [Q_W-1:0]                 v_q;
  logic [Q_W-1:0][2:0][NW_W-1:0]  rem_q;
  logic [Q_W-1:0][2:0][Q_W-1:0]   quo_q;
  logic [Q_W-1:0][AW_W-1:0]       den_q;
  logic [Q_W:0]                   en;
  logic [Q_W-1:0][2:0][NW_W-1:0]  rem_d;
  logic [Q_W-1:0][2:0][Q_W-1:0]   quo_d;
  logic [Q_W-1:0][AW_W-1:0]       den_d;
  logic [AW_W-A_SH-1:0]           a_hi;

  always_comb begin
    en[Q_W] = out_o.ready;
    for (int s = Q_W - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end
  assign in_ready_o = en[0];

  // One quotient bit per stage, MSB first, restoring.
  always_comb begin
    logic [2:0][NW_W-1:0] rin;
    logic [2:0][Q_W-1:0]  qin;
    logic [AW_W-1:0]      din;
    logic [NW_W-1:0]      dsh;
    for (int s = 0; s < Q_W; s++) begin
      if (s == 0) begin
        rin = sum_i.num;
        qin = '0;
        din = sum_i.den;
      end else begin
        rin = rem_q[s-1];
        qin = quo_q[s-1];
        din = den_q[s-1];
      end
      dsh = NW_W'(din) << (Q_W - 1 - s);
      for (int c = 0; c < 3; c++) begin
        rem_d[s][c] = rin[c];
        quo_d[s][c] = qin[c];
        if (rin[c] >= dsh) begin
          rem_d[s][c]               = rin[c] - dsh;
          quo_d[s][c][Q_W - 1 - s]  = 1'b1;
        end
      end
      den_d[s] = din;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < Q_W; s++) begin
        if (en[s]) v_q[s] <= (s == 0) ? in_valid_i : v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < Q_W; s++) begin
      if (en[s]) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_d[s];
      end
    end
  end

  assign a_hi = den_q[Q_W-1][AW_W-1:A_SH];

  assign out_o.valid     = v_q[Q_W-1];
  assign out_o.out_red   = (den_q[Q_W-1] == '0) ? '0 : quo_q[Q_W-1][0];
  assign out_o.out_green = (den_q[Q_W-1] == '0) ? '0 : quo_q[Q_W-1][1];
  assign out_o.out_blue  = (den_q[Q_W-1] == '0) ? '0 : quo_q[Q_W-1][2];
  assign out_o.out_alpha = (a_hi > (AW_W-A_SH)'({CH_W{1'b1}})) ? '1 : CH_W'(a_hi);

endmodule
